// ===== rtl/tcphb_pkg.sv =====
// Shared types, constants and checksum helpers for the TCP/IPv4 header builder.
// Depends on nothing; every other file of the block uses it by scoped names.
package tcphb_pkg;

	// Datagram size limit and what follows from it
	localparam int DATAGRAM_BYTES   = 4096;
	localparam int HEADER_BYTES     = 60;
	localparam int TCP_HEADER_BYTES = 40;
	localparam int MAX_PAYLOAD      = DATAGRAM_BYTES - HEADER_BYTES;
	localparam int LEN_W            = $clog2(MAX_PAYLOAD + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

	// Header field constants
	localparam logic [7:0]  IP_VER_IHL  = 8'h45;
	localparam logic [7:0]  IP_TTL      = 8'd64;
	localparam logic [7:0]  IP_PROTO    = 8'd6;
	localparam logic [3:0]  TCP_OFFSET  = 4'd10;
	localparam logic [7:0]  FLAG_ACK    = 8'h10;
	localparam logic [7:0]  FLAG_PSH    = 8'h08;
	localparam logic [15:0] TCP_WINDOW  = 16'd5840;

	// Header word sequence
	localparam int HEADER_WORDS = 15;
	localparam int WIDX_W       = $clog2(HEADER_WORDS);
	localparam logic [WIDX_W-1:0] W_IP_LEN    = WIDX_W'(0);
	localparam logic [WIDX_W-1:0] W_IP_IDENT  = WIDX_W'(1);
	localparam logic [WIDX_W-1:0] W_IP_CHECK  = WIDX_W'(2);
	localparam logic [WIDX_W-1:0] W_IP_SRC    = WIDX_W'(3);
	localparam logic [WIDX_W-1:0] W_IP_DST    = WIDX_W'(4);
	localparam logic [WIDX_W-1:0] W_TCP_PORTS = WIDX_W'(5);
	localparam logic [WIDX_W-1:0] W_TCP_SEQ   = WIDX_W'(6);
	localparam logic [WIDX_W-1:0] W_TCP_ACK   = WIDX_W'(7);
	localparam logic [WIDX_W-1:0] W_TCP_FLAGS = WIDX_W'(8);
	localparam logic [WIDX_W-1:0] W_TCP_CHECK = WIDX_W'(9);
	localparam logic [WIDX_W-1:0] W_LAST      = WIDX_W'(HEADER_WORDS - 1);

	// Segment queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register map
	localparam int CFG_ADDR_W = 5;
	localparam logic [CFG_ADDR_W-3:0] REG_SRC_ADDR = 3'd0;
	localparam logic [CFG_ADDR_W-3:0] REG_DST_ADDR = 3'd1;
	localparam logic [CFG_ADDR_W-3:0] REG_SRC_PORT = 3'd2;
	localparam logic [CFG_ADDR_W-3:0] REG_DST_PORT = 3'd3;
	localparam logic [CFG_ADDR_W-3:0] REG_IDENT    = 3'd4;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        has_byte;
		logic        last;
		logic [31:0] seq_no;
		logic [31:0] ack_no;
		logic        push_req;
	} seg_word_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic        too_long;
		logic        end_of_header;
	} hdr_word_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] peer_port;
		logic [15:0] ident;
	} cfg_t;

	// One finished segment as handed from front to back
	typedef struct packed {
		logic             too_long;
		logic [LEN_W-1:0] len;
		logic [15:0]      sum;
		logic [31:0]      seq;
		logic [31:0]      ack;
		logic             push;
	} desc_t;

	// Ones-complement add with end-around carry; never carries twice
	function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	function automatic logic [15:0] sum4(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		return add16(add16(a, b), add16(c, d));
	endfunction

endpackage

// ===== rtl/tcphb_front.sv =====
// Front end: takes payload bytes, pairs them and keeps the running checksum.
// Pushes one segment descriptor into the queue on each last word. Uses tcphb_pkg.
module tcphb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_ready,
	input  tcphb_pkg::seg_word_t seg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output tcphb_pkg::desc_t     q_data
);

	logic [15:0]                 sum_q, sum_n;
	logic [tcphb_pkg::LEN_W-1:0] cnt_q, cnt_n;
	logic [7:0]                  held_q, held_n;
	logic                        odd_q, odd_n;
	logic                        ovf_q, ovf_n;
	logic                        accept;

	assign seg_ready = !q_full;
	assign accept    = seg_valid && seg_ready;
	assign q_push    = accept && seg_data.last;

	// Next segment state for this word
	always_comb begin
		sum_n  = sum_q;
		cnt_n  = cnt_q;
		held_n = held_q;
		odd_n  = odd_q;
		ovf_n  = ovf_q;
		if (seg_data.has_byte && !ovf_q) begin
			if (cnt_q >= tcphb_pkg::MAX_LEN) begin
				ovf_n = 1'b1;
			end else begin
				if (!odd_q) begin
					held_n = seg_data.payload_byte;
					odd_n  = 1'b1;
				end else begin
					sum_n  = tcphb_pkg::add16(sum_q, {held_q, seg_data.payload_byte});
					held_n = 8'd0;
					odd_n  = 1'b0;
				end
				cnt_n = cnt_q + 1'b1;
			end
		end
	end

	// Descriptor: odd trailing byte padded with a zero low byte
	always_comb begin
		q_data.too_long = ovf_n;
		q_data.len      = cnt_n;
		q_data.sum      = odd_n ? tcphb_pkg::add16(sum_n, {held_n, 8'd0}) : sum_n;
		q_data.seq      = seg_data.seq_no;
		q_data.ack      = seg_data.ack_no;
		q_data.push     = seg_data.push_req;
	end

	// Segment state; cleared at segment end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			held_q <= '0;
			odd_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (seg_data.last) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				held_q <= '0;
				odd_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				sum_q  <= sum_n;
				cnt_q  <= cnt_n;
				held_q <= held_n;
				odd_q  <= odd_n;
				ovf_q  <= ovf_n;
			end
		end
	end

endmodule

// ===== rtl/tcphb_queue.sv =====
// Short descriptor queue that decouples the front end from header emission.
// Flip-flop storage, one push and one pop port. Uses tcphb_pkg.
module tcphb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcphb_pkg::desc_t din,
	output logic             full,
	output logic             not_empty,
	input  logic             pop,
	output tcphb_pkg::desc_t dout
);

	tcphb_pkg::desc_t             mem_q [tcphb_pkg::QUEUE_DEPTH];
	logic [tcphb_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tcphb_pkg::QPTR_W:0]   count_q;
	logic                         do_push, do_pop;

	assign full      = (count_q == (tcphb_pkg::QPTR_W+1)'(tcphb_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

// ===== rtl/tcphb_back.sv =====
// Back end: finishes both checksums in two stages and emits fifteen header
// words (or one error word) per segment through an output register. Uses tcphb_pkg.
module tcphb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcphb_pkg::cfg_t      cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  tcphb_pkg::desc_t     q_data,
	output logic                 hdr_valid,
	input  logic                 hdr_ready,
	output tcphb_pkg::hdr_word_t hdr_data
);

	logic                         valid_s1, valid_s2;
	tcphb_pkg::desc_t             desc_s1, desc_s2;
	logic [15:0]                  ipg_s1 [2];
	logic [15:0]                  tcpg_s1 [4];
	logic [15:0]                  ipck_s2, tcpck_s2;
	logic [tcphb_pkg::WIDX_W-1:0] widx_q;
	logic                         out_valid_q;
	tcphb_pkg::hdr_word_t         out_q, out_n;

	logic        out_free, last_word_s2, s2_free, s1_free, emit;
	logic [15:0] tot_len, tcp_len, flags_hi, flags_hi_s2;
	logic [7:0]  flags;

	// Handshake between stages
	assign out_free     = !out_valid_q || hdr_ready;
	assign last_word_s2 = desc_s2.too_long || (widx_q == tcphb_pkg::W_LAST);
	assign s2_free      = !valid_s2 || (out_free && last_word_s2);
	assign s1_free      = !valid_s1 || s2_free;
	assign q_pop        = q_valid && s1_free;
	assign emit         = valid_s2 && out_free;

	assign hdr_valid = out_valid_q;
	assign hdr_data  = out_q;

	// Checksum terms of the segment at the queue head
	assign tot_len  = 16'(tcphb_pkg::HEADER_BYTES) + 16'(q_data.len);
	assign tcp_len  = 16'(tcphb_pkg::TCP_HEADER_BYTES) + 16'(q_data.len);
	assign flags    = tcphb_pkg::FLAG_ACK | (q_data.push ? tcphb_pkg::FLAG_PSH : 8'd0);
	assign flags_hi = {tcphb_pkg::TCP_OFFSET, 4'd0, flags};

	// Stage 1: group sums of four terms each
	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_s1    <= q_data;
			ipg_s1[0]  <= tcphb_pkg::sum4({tcphb_pkg::IP_VER_IHL, 8'd0}, tot_len, cfg.ident,
				{tcphb_pkg::IP_TTL, tcphb_pkg::IP_PROTO});
			ipg_s1[1]  <= tcphb_pkg::sum4(cfg.src_addr[31:16], cfg.src_addr[15:0],
				cfg.dst_addr[31:16], cfg.dst_addr[15:0]);
			tcpg_s1[0] <= tcphb_pkg::sum4(q_data.sum, cfg.src_addr[31:16], cfg.src_addr[15:0],
				cfg.dst_addr[31:16]);
			tcpg_s1[1] <= tcphb_pkg::sum4(cfg.dst_addr[15:0], {8'd0, tcphb_pkg::IP_PROTO},
				tcp_len, cfg.src_port);
			tcpg_s1[2] <= tcphb_pkg::sum4(cfg.peer_port, q_data.seq[31:16], q_data.seq[15:0],
				q_data.ack[31:16]);
			tcpg_s1[3] <= tcphb_pkg::sum4(q_data.ack[15:0], flags_hi, tcphb_pkg::TCP_WINDOW,
				16'd0);
		end
	end

	// Stage 2: final sums, complemented into the checksum fields
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			desc_s2  <= desc_s1;
			ipck_s2  <= ~tcphb_pkg::add16(ipg_s1[0], ipg_s1[1]);
			tcpck_s2 <= ~tcphb_pkg::sum4(tcpg_s1[0], tcpg_s1[1], tcpg_s1[2], tcpg_s1[3]);
		end
	end

	// Header word selection
	assign flags_hi_s2 = {tcphb_pkg::TCP_OFFSET, 4'd0,
		tcphb_pkg::FLAG_ACK | (desc_s2.push ? tcphb_pkg::FLAG_PSH : 8'd0)};

	always_comb begin
		out_n.too_long      = desc_s2.too_long;
		out_n.end_of_header = last_word_s2;
		if (desc_s2.too_long) begin
			out_n.header_word = 32'd0;
		end else begin
			case (widx_q)
				tcphb_pkg::W_IP_LEN: begin
					out_n.header_word = {tcphb_pkg::IP_VER_IHL, 8'd0,
						16'(tcphb_pkg::HEADER_BYTES) + 16'(desc_s2.len)};
				end
				tcphb_pkg::W_IP_IDENT:  out_n.header_word = {cfg.ident, 16'd0};
				tcphb_pkg::W_IP_CHECK: begin
					out_n.header_word = {tcphb_pkg::IP_TTL, tcphb_pkg::IP_PROTO, ipck_s2};
				end
				tcphb_pkg::W_IP_SRC:    out_n.header_word = cfg.src_addr;
				tcphb_pkg::W_IP_DST:    out_n.header_word = cfg.dst_addr;
				tcphb_pkg::W_TCP_PORTS: out_n.header_word = {cfg.src_port, cfg.peer_port};
				tcphb_pkg::W_TCP_SEQ:   out_n.header_word = desc_s2.seq;
				tcphb_pkg::W_TCP_ACK:   out_n.header_word = desc_s2.ack;
				tcphb_pkg::W_TCP_FLAGS: out_n.header_word = {flags_hi_s2, tcphb_pkg::TCP_WINDOW};
				tcphb_pkg::W_TCP_CHECK: out_n.header_word = {tcpck_s2, 16'd0};
				// option bytes
				default:                out_n.header_word = 32'd0;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)  valid_s1    <= q_valid;
			if (s2_free)  valid_s2    <= valid_s1;
			if (out_free) out_valid_q <= valid_s2;
			if (emit) begin
				if (last_word_s2) widx_q <= '0;
				else              widx_q <= widx_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) out_q <= out_n;
	end

endmodule

// ===== rtl/tcp_ipv4_header_builder_top.sv =====
// Top level of the TCP/IPv4 header builder: register port, front, queue, back.
// Depends on tcphb_pkg, tcphb_front, tcphb_queue and tcphb_back.
//
//   channel   dir   handshake                   word
//   seg       in    seg_valid / seg_ready       tcphb_pkg::seg_word_t
//   hdr       out   hdr_valid / hdr_ready       tcphb_pkg::hdr_word_t
//   apb       in    psel/penable, pready = 1    5 registers at 4*i
//
// Payload bytes are taken one per cycle; seg_ready drops only while the
// four-entry segment queue is full.
// Each segment yields 15 header words (one for an oversize segment), one word per cycle
// while hdr_ready is high; they pass stage 1, stage 2 and the output register.
// hdr_ready low holds the output word and back-pressures the queue.
// Reset clears all control state at once; there is no clearing pass.
module tcp_ipv4_header_builder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 seg_valid,
	output logic                                 seg_ready,
	input  tcphb_pkg::seg_word_t                 seg_data,
	output logic                                 hdr_valid,
	input  logic                                 hdr_ready,
	output tcphb_pkg::hdr_word_t                 hdr_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tcphb_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	tcphb_pkg::cfg_t                   cfg_q;
	tcphb_pkg::desc_t                  push_data, pop_data;
	logic                              q_push, q_full, q_not_empty, q_pop;
	logic [tcphb_pkg::CFG_ADDR_W-3:0]  reg_idx;
	logic                              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[tcphb_pkg::CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				tcphb_pkg::REG_SRC_ADDR: cfg_q.src_addr  <= pwdata;
				tcphb_pkg::REG_DST_ADDR: cfg_q.dst_addr  <= pwdata;
				tcphb_pkg::REG_SRC_PORT: cfg_q.src_port  <= pwdata[15:0];
				tcphb_pkg::REG_DST_PORT: cfg_q.peer_port <= pwdata[15:0];
				tcphb_pkg::REG_IDENT:    cfg_q.ident     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			tcphb_pkg::REG_SRC_ADDR: prdata = cfg_q.src_addr;
			tcphb_pkg::REG_DST_ADDR: prdata = cfg_q.dst_addr;
			tcphb_pkg::REG_SRC_PORT: prdata = {16'd0, cfg_q.src_port};
			tcphb_pkg::REG_DST_PORT: prdata = {16'd0, cfg_q.peer_port};
			tcphb_pkg::REG_IDENT:    prdata = {16'd0, cfg_q.ident};
			default:                 prdata = 32'd0;
		endcase
	end

	tcphb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg_data  (seg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	tcphb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.dout      (pop_data)
	);

	tcphb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_not_empty),
		.q_pop     (q_pop),
		.q_data    (pop_data),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr_data  (hdr_data)
	);

endmodule

// ===== rtl/tcphb_checker.sv =====
// Port-level checks on the header output of the TCP/IPv4 header builder.
// Depends on tcphb_pkg; bound to tcp_ipv4_header_builder_top below.
module tcphb_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hdr_valid,
	input  logic                 hdr_ready,
	input  tcphb_pkg::hdr_word_t hdr_data
);

	logic [tcphb_pkg::WIDX_W-1:0] idx_q;

	// Position of the current word within its segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (hdr_valid && hdr_ready) begin
			if (hdr_data.end_of_header) idx_q <= '0;
			else                        idx_q <= idx_q + 1'b1;
		end
	end

	// A stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_data))
		else $error("header word changed while stalled");

	// Error result stands alone, zero, at the start of a segment
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_data.too_long |->
			hdr_data.end_of_header && hdr_data.header_word == 32'd0 && idx_q == '0)
		else $error("malformed error result");

	// A header ends exactly on its fifteenth word
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_data.too_long |->
			hdr_data.end_of_header == (idx_q == tcphb_pkg::W_LAST))
		else $error("header length wrong");

	// First word carries version and IHL
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_data.too_long && idx_q == tcphb_pkg::W_IP_LEN |->
			hdr_data.header_word[31:24] == tcphb_pkg::IP_VER_IHL)
		else $error("first header word lacks version and IHL");

endmodule

bind tcp_ipv4_header_builder_top tcphb_checker u_tcphb_checker (.*);

// ===== tb/tcp_ipv4_header_builder_top_tb.sv =====
// Self-checking testbench for the TCP/IPv4 header builder: streams payload segments,
// predicts the fifteen header words (or the oversize error word) and checks each one.
// Depends on tcphb_pkg and tcp_ipv4_header_builder_top.
module tcp_ipv4_header_builder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Header constants as the predictor sees them
	localparam int          PAYLOAD_LIMIT  = 4096 - 60;
	localparam int          IP_HDR_LEN     = 60;
	localparam int          TCP_HDR_LEN    = 40;
	localparam logic [7:0]  TTL_VALUE      = 8'd64;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  ACK_FLAG       = 8'h10;
	localparam logic [7:0]  PSH_FLAG       = 8'h08;
	localparam logic [15:0] WINDOW_SIZE    = 16'd5840;
	localparam int          WORDS_PER_HDR  = 15;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 20;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic                                     clk;
	logic                                     arst_n;
	logic                                     seg_valid;
	logic                                     seg_ready;
	tcphb_pkg::seg_word_t                     seg_data;
	logic                                     hdr_valid;
	logic                                     hdr_ready;
	tcphb_pkg::hdr_word_t                     hdr_data;
	logic                                     psel;
	logic                                     penable;
	logic                                     pwrite;
	logic [tcphb_pkg::CFG_ADDR_W-1:0]         paddr;
	logic [31:0]                              pwdata;
	logic [31:0]                              prdata;
	logic                                     pready;

	tcp_ipv4_header_builder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg_data  (seg_data),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr_data  (hdr_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Predictor copy of the registers
	logic [31:0] cfg_src_addr;
	logic [31:0] cfg_dst_addr;
	logic [15:0] cfg_src_port;
	logic [15:0] cfg_peer_port;
	logic [15:0] cfg_ident;

	// Predictor copy of the per-segment accumulator
	logic [15:0] pay_sum;
	int          pay_count;
	logic [7:0]  pay_held;
	bit          pay_odd;
	bit          pay_over;

	tcphb_pkg::hdr_word_t hdr_expect_q[$];
	tcphb_pkg::hdr_word_t hdr_expect_w;

	bit src_gaps;
	bit sink_stalls;
	int mismatches;
	int idle_cycles;
	int seg_words_sent;
	int segments_sent;
	int payload_bytes_sent;
	int oversize_sent;
	int words_checked;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ones-complement fold down to 16 bits
	function automatic logic [15:0] csum_fold(input logic [31:0] s);
		while (s[31:16] != 16'h0)
			s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
		return s[15:0];
	endfunction

	// Add both halves of a 32-bit word into a ones-complement sum
	function automatic logic [15:0] csum_add32(input logic [15:0] acc, input logic [31:0] w);
		logic [15:0] t;
		t = csum_fold({16'h0, acc} + {16'h0, w[31:16]});
		return csum_fold({16'h0, t} + {16'h0, w[15:0]});
	endfunction

	function automatic void clear_payload_state();
		pay_sum   = 16'h0;
		pay_count = 0;
		pay_held  = 8'h0;
		pay_odd   = 1'b0;
		pay_over  = 1'b0;
	endfunction

	// Accumulate one accepted word; on the segment end queue the expected header
	function automatic void predict_header(input tcphb_pkg::seg_word_t w);
		logic [31:0]          hw[WORDS_PER_HDR];
		logic [15:0]          s;
		logic [7:0]           flags;
		tcphb_pkg::hdr_word_t r;
		int                   k;
		if (w.has_byte && !pay_over) begin
			if (pay_count >= PAYLOAD_LIMIT) begin
				pay_over = 1'b1;
			end else begin
				if (!pay_odd) begin
					pay_held = w.payload_byte;
					pay_odd  = 1'b1;
				end else begin
					pay_sum  = csum_add32(pay_sum, {16'h0, pay_held, w.payload_byte});
					pay_held = 8'h0;
					pay_odd  = 1'b0;
				end
				pay_count++;
			end
		end
		if (!w.last)
			return;
		// oversize segment: a single error word
		if (pay_over) begin
			r.header_word   = 32'h0;
			r.too_long      = 1'b1;
			r.end_of_header = 1'b1;
			hdr_expect_q.insert(hdr_expect_q.size(), r);
			clear_payload_state();
			return;
		end
		// odd length: pad the held byte with a zero low byte
		if (pay_odd)
			pay_sum = csum_add32(pay_sum, {16'h0, pay_held, 8'h00});
		flags = ACK_FLAG | (w.push_req ? PSH_FLAG : 8'h00);
		for (k = 0; k < WORDS_PER_HDR; k++)
			hw[k] = 32'h0;
		hw[0] = {4'd4, 4'd5, 8'h00, 16'(IP_HDR_LEN + pay_count)};
		hw[1] = {cfg_ident, 16'h0};
		hw[2] = {TTL_VALUE, PROTO_TCP, 16'h0};
		hw[3] = cfg_src_addr;
		hw[4] = cfg_dst_addr;
		s = 16'h0;
		for (k = 0; k < 5; k++)
			s = csum_add32(s, hw[k]);
		hw[2][15:0] = ~s;
		hw[5] = {cfg_src_port, cfg_peer_port};
		hw[6] = w.seq_no;
		hw[7] = w.ack_no;
		hw[8] = {4'd10, 4'h0, flags, WINDOW_SIZE};
		// TCP checksum: pseudo-header, TCP header with zero checksum, payload
		s = pay_sum;
		s = csum_add32(s, cfg_src_addr);
		s = csum_add32(s, cfg_dst_addr);
		s = csum_add32(s, {8'h00, PROTO_TCP, 16'(TCP_HDR_LEN + pay_count)});
		for (k = 5; k < WORDS_PER_HDR; k++)
			s = csum_add32(s, hw[k]);
		hw[9] = {~s, 16'h0};
		for (k = 0; k < WORDS_PER_HDR; k++) begin
			r.header_word   = hw[k];
			r.too_long      = 1'b0;
			r.end_of_header = (k == WORDS_PER_HDR - 1);
			hdr_expect_q.insert(hdr_expect_q.size(), r);
		end
		clear_payload_state();
	endfunction

	// Check every accepted header word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && hdr_valid && hdr_ready) begin
			words_checked++;
			if (hdr_expect_q.size() == 0) begin
				$error("unexpected header word %h too_long %b end_of_header %b",
					hdr_data.header_word, hdr_data.too_long, hdr_data.end_of_header);
				mismatches++;
			end else begin
				hdr_expect_w = hdr_expect_q.pop_front();
				if (hdr_data.header_word !== hdr_expect_w.header_word) begin
					$error("header_word expected %h got %h",
						hdr_expect_w.header_word, hdr_data.header_word);
					mismatches++;
				end
				if (hdr_data.too_long !== hdr_expect_w.too_long) begin
					$error("too_long expected %b got %b",
						hdr_expect_w.too_long, hdr_data.too_long);
					mismatches++;
				end
				if (hdr_data.end_of_header !== hdr_expect_w.end_of_header) begin
					$error("end_of_header expected %b got %b",
						hdr_expect_w.end_of_header, hdr_data.end_of_header);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: cycles with no handshake on any port
	always @(posedge clk) begin
		if ((seg_valid && seg_ready) || (hdr_valid && hdr_ready) || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Header sink: random stall bursts while enabled
	initial begin
		hdr_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				hdr_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			hdr_ready <= 1'b1;
		end
	end

	// Register write through the APB port; also updates the predictor copy
	task automatic write_reg(input logic [tcphb_pkg::CFG_ADDR_W-3:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			tcphb_pkg::REG_SRC_ADDR: cfg_src_addr  = val;
			tcphb_pkg::REG_DST_ADDR: cfg_dst_addr  = val;
			tcphb_pkg::REG_SRC_PORT: cfg_src_port  = val[15:0];
			tcphb_pkg::REG_DST_PORT: cfg_peer_port = val[15:0];
			tcphb_pkg::REG_IDENT:    cfg_ident     = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, wait for every expected word, then let the pipeline settle
	task automatic wait_drained();
		@(negedge clk);
		seg_valid <= 1'b0;
		while (hdr_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_config(input logic [31:0] src, input logic [31:0] dst,
			input logic [31:0] sport, input logic [31:0] dport, input logic [31:0] ident);
		wait_drained();
		write_reg(tcphb_pkg::REG_SRC_ADDR, src);
		write_reg(tcphb_pkg::REG_DST_ADDR, dst);
		write_reg(tcphb_pkg::REG_SRC_PORT, sport);
		write_reg(tcphb_pkg::REG_DST_PORT, dport);
		write_reg(tcphb_pkg::REG_IDENT, ident);
	endtask

	// Send one segment word; returns at the edge that accepts it
	task automatic send_seg_word(input tcphb_pkg::seg_word_t w);
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			seg_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		seg_valid <= 1'b1;
		seg_data  <= w;
		do @(posedge clk); while (!seg_ready);
		predict_header(w);
		seg_words_sent++;
		if (w.has_byte)
			payload_bytes_sent++;
	endtask

	function automatic tcphb_pkg::seg_word_t make_word(input fill_t fill);
		tcphb_pkg::seg_word_t w;
		case (fill)
			FILL_ZERO: w = '0;
			FILL_ONES: w = '1;
			default: begin
				w.payload_byte = 8'($urandom);
				w.has_byte     = 1'($urandom);
				w.last         = 1'($urandom);
				w.seq_no       = $urandom;
				w.ack_no       = $urandom;
				w.push_req     = 1'($urandom);
			end
		endcase
		return w;
	endfunction

	// One segment of n_bytes; the end marker rides on the final byte or on an empty word.
	// Empty non-final words are sprinkled in at noise_pct percent.
	task automatic send_segment(input int n_bytes, input bit end_on_byte, input int noise_pct,
			input fill_t fill);
		tcphb_pkg::seg_word_t w;
		int n_words;
		int i;
		n_words = (end_on_byte && n_bytes > 0) ? n_bytes : n_bytes + 1;
		for (i = 0; i < n_words; i++) begin
			if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
				w = make_word(fill);
				w.has_byte = 1'b0;
				w.last     = 1'b0;
				send_seg_word(w);
			end
			w = make_word(fill);
			w.has_byte = (i < n_bytes);
			w.last     = (i == n_words - 1);
			send_seg_word(w);
		end
		segments_sent++;
		if (n_bytes > PAYLOAD_LIMIT)
			oversize_sent++;
	endtask

	// Reset register values, empty and tiny segments, field extremes
	task automatic test_short_segments();
		send_segment(0, 1'b0, 0, FILL_ZERO);
		program_config('1, '1, '1, '1, '1);
		send_segment(1, 1'b1, 0, FILL_ONES);
		send_segment(0, 1'b0, 0, FILL_ONES);
		send_segment(2, 1'b0, 0, FILL_ZERO);
		send_segment(3, 1'b1, 50, FILL_RANDOM);
		program_config(32'h0, '1, 32'h0, 32'h0000_ffff, 32'h0);
		send_segment(4, 1'b1, 0, FILL_RANDOM);
		send_segment(5, 1'b0, 0, FILL_ONES);
	endtask

	// Random segments, mostly short, until n_words more words have gone in
	task automatic test_random_traffic(input int n_words);
		int stop_at;
		int n;
		stop_at = seg_words_sent + n_words;
		while (seg_words_sent < stop_at) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
			send_segment(n, 1'($urandom), 10, FILL_RANDOM);
		end
	endtask

	// Main sequence
	initial begin
		arst_n      = 1'b0;
		seg_valid   = 1'b0;
		seg_data    = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		mismatches  = 0;
		idle_cycles = 0;
		seg_words_sent     = 0;
		segments_sent      = 0;
		payload_bytes_sent = 0;
		oversize_sent      = 0;
		words_checked      = 0;
		cfg_src_addr  = '0;
		cfg_dst_addr  = '0;
		cfg_src_port  = '0;
		cfg_peer_port = '0;
		cfg_ident     = '0;
		clear_payload_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_segments();
		program_config($urandom, $urandom, $urandom, $urandom, $urandom);
		test_random_traffic(25);
		program_config('1, 32'h0, 32'h0, '1, $urandom);
		test_random_traffic(25);
		// closing stretch at full rate on both sides
		program_config($urandom, $urandom, $urandom, $urandom, $urandom);
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		test_random_traffic(25);
		wait_drained();

		$display("Sent %0d segments (%0d words, %0d payload bytes, %0d oversize)",
			segments_sent, seg_words_sent, payload_bytes_sent, oversize_sent);
		$display("Checked %0d header words under reset values and five register sets, %0d mismatches",
			words_checked, mismatches);
		if (mismatches == 0 && hdr_expect_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tcphb_pkg.sv
rtl/tcphb_front.sv
rtl/tcphb_queue.sv
rtl/tcphb_back.sv
rtl/tcp_ipv4_header_builder_top.sv
rtl/tcphb_checker.sv
tb/tcp_ipv4_header_builder_top_tb.sv
